// ===== sv/ide_pkg.sv =====
// ----------------------------------------------------------------------------
// Instruction decode/execute package
// Opcodes, format and memory codes, and the word passed from front to back.
// ----------------------------------------------------------------------------
package ide_pkg;

	localparam int IDE_QUEUE_DEPTH = 4;

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_MUL   = 4'd2,
		OP_MOVI  = 4'd3,
		OP_JEQ   = 4'd4,
		OP_AND   = 4'd5,
		OP_XORI  = 4'd6,
		OP_JUMP  = 4'd7,
		OP_SLL   = 4'd8,
		OP_SRL   = 4'd9,
		OP_LOAD  = 4'd10,
		OP_STORE = 4'd11
	} opcode_t;

	typedef enum logic [1:0] {
		FMT_REG  = 2'd0,
		FMT_IMM  = 2'd1,
		FMT_JUMP = 2'd2,
		FMT_NONE = 2'd3
	} format_t;

	typedef enum logic [1:0] {
		MEM_NONE  = 2'd0,
		MEM_LOAD  = 2'd1,
		MEM_STORE = 2'd2
	} mem_op_t;

	typedef struct packed {
		opcode_t      op;
		logic         illegal;
		format_t      fmt;
		logic [4:0]   dest_index;
		logic [12:0]  shamt;
		logic [17:0]  imm;
		logic [27:0]  addr;
		logic [31:0]  dest_value;
		logic [31:0]  src_value;
		logic [31:0]  src2_value;
		logic [31:0]  pc_value;
	} ide_item_t;

endpackage

// ===== sv/ide_front.sv =====
// ----------------------------------------------------------------------------
// Instruction front end
// Accepts instruction words, splits the fields, classifies the opcode and
// holds the decoded word until the queue takes it.
// ----------------------------------------------------------------------------
module ide_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [31:0]       instruction_word,
	input  logic [31:0]       dest_value,
	input  logic [31:0]       src_value,
	input  logic [31:0]       src2_value,
	input  logic [31:0]       pc_value,
	input  logic              queue_full,
	output logic              push,
	output ide_pkg::ide_item_t item
);
	import ide_pkg::*;

	logic      valid_s1;
	ide_item_t item_s1;
	ide_item_t decoded;
	logic      accept;

	always_comb begin
		decoded            = '0;
		decoded.op         = opcode_t'(instruction_word[31:28]);
		decoded.dest_index = instruction_word[27:23];
		decoded.shamt      = instruction_word[12:0];
		decoded.imm        = instruction_word[17:0];
		decoded.addr       = instruction_word[27:0];
		decoded.dest_value = dest_value;
		decoded.src_value  = src_value;
		decoded.src2_value = src2_value;
		decoded.pc_value   = pc_value;
		decoded.illegal    = 1'b0;
		case (instruction_word[31:28])
			OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_SLL, OP_SRL: decoded.fmt = FMT_REG;
			OP_MOVI, OP_JEQ, OP_XORI, OP_LOAD, OP_STORE:    decoded.fmt = FMT_IMM;
			OP_JUMP:                                        decoded.fmt = FMT_JUMP;
			default: begin
				decoded.fmt     = FMT_NONE;
				decoded.illegal = 1'b1;
			end
		endcase
	end

	assign in_stall = valid_s1 && queue_full;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && !queue_full;
	assign item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= decoded;
		end
	end

endmodule

// ===== sv/ide_queue.sv =====
// ----------------------------------------------------------------------------
// Decoded word queue
// Short FIFO between front end and execute back end.
// ----------------------------------------------------------------------------
module ide_queue #(
	parameter int Depth = ide_pkg::IDE_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ide_pkg::ide_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output ide_pkg::ide_item_t head_item
);
	import ide_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	ide_item_t         mem_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== sv/ide_back.sv =====
// ----------------------------------------------------------------------------
// Execute back end
// Executes the head word of the queue and holds the result in the output
// register until the receiver takes it.
// ----------------------------------------------------------------------------
module ide_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               not_empty,
	input  ide_pkg::ide_item_t head_item,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        result_value,
	output logic [4:0]         dest_index,
	output logic               write_register,
	output logic               write_pc,
	output logic [1:0]         memory_op,
	output logic [31:0]        memory_address,
	output logic               flush_younger,
	output logic [1:0]         format_kind,
	output logic               illegal_opcode
);
	import ide_pkg::*;

	logic        out_valid_q;
	logic [31:0] result_q;
	logic [4:0]  dest_index_q;
	logic        wreg_q;
	logic        wpc_q;
	mem_op_t     mop_q;
	logic [31:0] maddr_q;
	logic        flush_q;
	format_t     fmt_q;
	logic        illegal_q;

	logic [31:0] res;
	logic [31:0] maddr;
	logic        wreg;
	logic        wpc;
	mem_op_t     mop;
	logic        flush;
	logic [31:0] imm_ext;
	logic        big_shift;

	assign imm_ext   = {14'd0, head_item.imm};
	assign big_shift = (head_item.shamt[12:5] != '0);

	always_comb begin
		res   = '0;
		maddr = '0;
		wreg  = 1'b0;
		wpc   = 1'b0;
		mop   = MEM_NONE;
		flush = 1'b0;
		case (head_item.op)
			OP_ADD: begin
				res  = head_item.src_value + head_item.src2_value;
				wreg = 1'b1;
			end
			OP_SUB: begin
				res  = head_item.src_value - head_item.src2_value;
				wreg = 1'b1;
			end
			OP_MUL: begin
				res  = head_item.src_value * head_item.src2_value;
				wreg = 1'b1;
			end
			OP_MOVI: begin
				res  = imm_ext;
				wreg = 1'b1;
			end
			OP_JEQ: begin
				if (head_item.dest_value == head_item.src_value) begin
					res   = head_item.pc_value + imm_ext;
					wpc   = 1'b1;
					flush = 1'b1;
				end
			end
			OP_AND: begin
				res  = head_item.src_value & head_item.src2_value;
				wreg = 1'b1;
			end
			OP_XORI: begin
				res  = head_item.src_value ^ imm_ext;
				wreg = 1'b1;
			end
			OP_JUMP: begin
				res   = {head_item.pc_value[31:28], head_item.addr};
				wpc   = 1'b1;
				flush = 1'b1;
			end
			OP_SLL: begin
				res  = big_shift ? '0 : head_item.src_value << head_item.shamt[4:0];
				wreg = 1'b1;
			end
			OP_SRL: begin
				res  = big_shift ? '0 : head_item.src_value >> head_item.shamt[4:0];
				wreg = 1'b1;
			end
			OP_LOAD: begin
				wreg  = 1'b1;
				mop   = MEM_LOAD;
				maddr = head_item.src_value + imm_ext;
			end
			OP_STORE: begin
				res   = head_item.dest_value;
				mop   = MEM_STORE;
				maddr = head_item.src_value + imm_ext;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	assign pop = not_empty && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q     <= res;
			dest_index_q <= head_item.dest_index;
			wreg_q       <= wreg;
			wpc_q        <= wpc;
			mop_q        <= mop;
			maddr_q      <= maddr;
			flush_q      <= flush;
			fmt_q        <= head_item.fmt;
			illegal_q    <= head_item.illegal;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_value   = result_q;
	assign dest_index     = dest_index_q;
	assign write_register = wreg_q;
	assign write_pc       = wpc_q;
	assign memory_op      = mop_q;
	assign memory_address = maddr_q;
	assign flush_younger  = flush_q;
	assign format_kind    = fmt_q;
	assign illegal_opcode = illegal_q;

endmodule

// ===== sv/instruction_decode_execute.sv =====
// ----------------------------------------------------------------------------
// Instruction decode and execute
// Decodes one instruction word per cycle, while neither channel stalls, and
// executes it on the supplied register values and program counter.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with the instruction word, the three
// register values it names and the PC. A word is taken at a rising edge with
// in_valid high and in_stall low.
// Output channel: out_valid/out_stall with the result, write-back controls,
// memory op and address, flush and illegal flags; one result word per input.
// Path: accepting edge into the front register, then a queue write, then the
// output register. Throughput: one word per cycle while out_stall stays low,
// set by the combinational execute step feeding the output register.
// A stalled receiver holds the output register; the queue of QueueDepth words
// keeps absorbing input, and in_stall rises once it and the front register
// are full.
// Reset empties the front register, the queue and the output register; no
// other state is kept.
// ----------------------------------------------------------------------------
module instruction_decode_execute #(
	parameter int QueueDepth = ide_pkg::IDE_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instruction_word,
	input  logic [31:0] dest_value,
	input  logic [31:0] src_value,
	input  logic [31:0] src2_value,
	input  logic [31:0] pc_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_value,
	output logic [4:0]  dest_index,
	output logic        write_register,
	output logic        write_pc,
	output logic [1:0]  memory_op,
	output logic [31:0] memory_address,
	output logic        flush_younger,
	output logic [1:0]  format_kind,
	output logic        illegal_opcode
);
	import ide_pkg::*;

	ide_item_t push_item;
	ide_item_t head_item;
	logic      push;
	logic      pop;
	logic      queue_full;
	logic      not_empty;

	ide_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.instruction_word (instruction_word),
		.dest_value       (dest_value),
		.src_value        (src_value),
		.src2_value       (src2_value),
		.pc_value         (pc_value),
		.queue_full       (queue_full),
		.push             (push),
		.item             (push_item)
	);

	ide_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (not_empty),
		.head_item (head_item)
	);

	ide_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.not_empty      (not_empty),
		.head_item      (head_item),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_value   (result_value),
		.dest_index     (dest_index),
		.write_register (write_register),
		.write_pc       (write_pc),
		.memory_op      (memory_op),
		.memory_address (memory_address),
		.flush_younger  (flush_younger),
		.format_kind    (format_kind),
		.illegal_opcode (illegal_opcode)
	);

endmodule

// ===== sv/ide_checker.sv =====
// ----------------------------------------------------------------------------
// Instruction decode/execute checker
// Port-level properties of the decode/execute block, bound to the top level.
// ----------------------------------------------------------------------------
module ide_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] result_value,
	input logic        write_register,
	input logic        write_pc,
	input logic [1:0]  memory_op,
	input logic [31:0] memory_address,
	input logic        flush_younger,
	input logic [1:0]  format_kind,
	input logic        illegal_opcode
);
	import ide_pkg::*;

	a_illegal_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && illegal_opcode |-> !write_register && !write_pc &&
			memory_op == MEM_NONE && !flush_younger && format_kind == FMT_NONE &&
			result_value == '0)
		else $error("illegal opcode word carries side effects");

	a_flush_pc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> flush_younger == write_pc)
		else $error("flush and PC write disagree");

	a_no_mem_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && memory_op == MEM_NONE |-> memory_address == '0)
		else $error("memory address set without a memory op");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value))
		else $error("stalled output word changed");

endmodule

bind instruction_decode_execute ide_checker u_ide_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.result_value   (result_value),
	.write_register (write_register),
	.write_pc       (write_pc),
	.memory_op      (memory_op),
	.memory_address (memory_address),
	.flush_younger  (flush_younger),
	.format_kind    (format_kind),
	.illegal_opcode (illegal_opcode)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Instruction decode/execute testbench
// Sends instruction words with register and PC values through the input
// channel, predicts the result word of each one, and compares every result
// word field by field. Covers directed corner cases, random mixes,
// back-to-back traffic and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import ide_pkg::*;

	localparam int  CYCLE_LIMIT      = 200000;
	localparam int  HOLD_OFF_CYCLES  = 64;
	localparam int  DRAIN_CYCLES     = 8;
	localparam int  IDLE_PERCENT     = 9;
	localparam int  FIRST_ILLEGAL_OP = 12;
	localparam int  OPCODE_COUNT     = 16;
	localparam int  SHIFT_LIMIT      = 32;

	typedef struct packed {
		logic [31:0] result;
		logic [4:0]  dest;
		logic        wreg;
		logic        wpc;
		mem_op_t     mop;
		logic [31:0] maddr;
		logic        flush;
		format_t     fmt;
		logic        illegal;
	} exec_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] instruction_word = '0;
	logic [31:0] dest_value = '0;
	logic [31:0] src_value = '0;
	logic [31:0] src2_value = '0;
	logic [31:0] pc_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] result_value;
	logic [4:0]  dest_index;
	logic        write_register;
	logic        write_pc;
	logic [1:0]  memory_op;
	logic [31:0] memory_address;
	logic        flush_younger;
	logic [1:0]  format_kind;
	logic        illegal_opcode;

	exec_result_t pending_results[$];
	int           error_count = 0;
	int           cycle_count = 0;
	bit           idle_enable = 1'b1;
	bit           hold_off_pending = 1'b0;

	instruction_decode_execute DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.instruction_word(instruction_word),
		.dest_value     (dest_value),
		.src_value      (src_value),
		.src2_value     (src2_value),
		.pc_value       (pc_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_value   (result_value),
		.dest_index     (dest_index),
		.write_register (write_register),
		.write_pc       (write_pc),
		.memory_op      (memory_op),
		.memory_address (memory_address),
		.flush_younger  (flush_younger),
		.format_kind    (format_kind),
		.illegal_opcode (illegal_opcode)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic exec_result_t execute_instruction(input logic [31:0] word,
			input logic [31:0] dval, input logic [31:0] sval,
			input logic [31:0] s2val, input logic [31:0] pcval);
		exec_result_t r;
		logic [3:0]   op;
		logic [12:0]  shamt;
		logic [31:0]  imm;
		op      = word[31:28];
		shamt   = word[12:0];
		imm     = {14'd0, word[17:0]};
		r.result  = '0;
		r.dest    = word[27:23];
		r.wreg    = 1'b0;
		r.wpc     = 1'b0;
		r.mop     = MEM_NONE;
		r.maddr   = '0;
		r.flush   = 1'b0;
		r.fmt     = FMT_NONE;
		r.illegal = 1'b0;
		case (op)
			OP_ADD: begin
				r.result = sval + s2val;
				r.wreg = 1'b1;
				r.fmt = FMT_REG;
			end
			OP_SUB: begin
				r.result = sval - s2val;
				r.wreg = 1'b1;
				r.fmt = FMT_REG;
			end
			OP_MUL: begin
				r.result = sval * s2val;
				r.wreg = 1'b1;
				r.fmt = FMT_REG;
			end
			OP_MOVI: begin
				r.result = imm;
				r.wreg = 1'b1;
				r.fmt = FMT_IMM;
			end
			OP_JEQ: begin
				r.fmt = FMT_IMM;
				if (dval == sval) begin
					r.result = pcval + imm;
					r.wpc = 1'b1;
					r.flush = 1'b1;
				end
			end
			OP_AND: begin
				r.result = sval & s2val;
				r.wreg = 1'b1;
				r.fmt = FMT_REG;
			end
			OP_XORI: begin
				r.result = sval ^ imm;
				r.wreg = 1'b1;
				r.fmt = FMT_IMM;
			end
			OP_JUMP: begin
				r.result = {pcval[31:28], word[27:0]};
				r.wpc = 1'b1;
				r.flush = 1'b1;
				r.fmt = FMT_JUMP;
			end
			OP_SLL: begin
				r.result = (shamt >= SHIFT_LIMIT) ? '0 : sval << shamt;
				r.wreg = 1'b1;
				r.fmt = FMT_REG;
			end
			OP_SRL: begin
				r.result = (shamt >= SHIFT_LIMIT) ? '0 : sval >> shamt;
				r.wreg = 1'b1;
				r.fmt = FMT_REG;
			end
			OP_LOAD: begin
				r.wreg = 1'b1;
				r.mop = MEM_LOAD;
				r.maddr = sval + imm;
				r.fmt = FMT_IMM;
			end
			OP_STORE: begin
				r.result = dval;
				r.mop = MEM_STORE;
				r.maddr = sval + imm;
				r.fmt = FMT_IMM;
			end
			default: begin
				r.illegal = 1'b1;
			end
		endcase
		return r;
	endfunction

	task automatic send_word(input logic [31:0] word, input logic [31:0] dval,
			input logic [31:0] sval, input logic [31:0] s2val,
			input logic [31:0] pcval);
		while (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid         <= 1'b1;
		instruction_word <= word;
		dest_value       <= dval;
		src_value        <= sval;
		src2_value       <= s2val;
		pc_value         <= pcval;
		pending_results.push_back(execute_instruction(word, dval, sval, s2val, pcval));
		do @(posedge clk); while (in_stall);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		exec_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: result word with none expected, actual result %h",
					$time, result_value);
			end else begin
				want = pending_results.pop_front();
				check_field("result_value", want.result, result_value);
				check_field("dest_index", 32'(want.dest), 32'(dest_index));
				check_field("write_register", 32'(want.wreg), 32'(write_register));
				check_field("write_pc", 32'(want.wpc), 32'(write_pc));
				check_field("memory_op", 32'(want.mop), 32'(memory_op));
				check_field("memory_address", want.maddr, memory_address);
				check_field("flush_younger", 32'(want.flush), 32'(flush_younger));
				check_field("format_kind", 32'(want.fmt), 32'(format_kind));
				check_field("illegal_opcode", 32'(want.illegal), 32'(illegal_opcode));
			end
		end
	end

	// hold off for a long stretch on request, else stall at random while idle cycles are enabled
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= idle_enable && ($urandom_range(99) < IDLE_PERCENT);
			end
		end
	end

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return $urandom_range(SHIFT_LIMIT);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random_word();
		logic [31:0] word;
		logic [31:0] dval;
		logic [31:0] sval;
		logic [3:0]  op;
		word = $urandom;
		dval = pick_operand();
		sval = pick_operand();
		if ($urandom_range(9) == 0)
			op = 4'($urandom_range(OPCODE_COUNT - 1));
		else
			op = 4'($urandom_range(OP_STORE));
		word[31:28] = op;
		if (op == OP_SLL || op == OP_SRL) begin
			case ($urandom_range(3))
				0: word[12:0] = 13'($urandom_range(SHIFT_LIMIT - 1));
				1: word[12:0] = 13'(SHIFT_LIMIT);
				default: ;
			endcase
		end
		if (op == OP_JEQ && $urandom_range(1))
			dval = sval;
		send_word(word, dval, sval, pick_operand(), pick_operand());
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_directed();
		send_word({OP_ADD, 28'hFFF_FFFF}, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h0);
		send_word({OP_SUB, 28'h000_0000}, 32'h0, 32'h0, 32'h1, 32'hFFFF_FFFF);
		send_word({OP_MUL, 28'h5A5_A5A5}, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
		send_word({OP_MOVI, 28'hFFF_FFFF}, 32'h0, 32'h0, 32'h0, 32'h0);
		send_word({OP_MOVI, 28'h000_0000}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
		send_word({OP_JEQ, 28'h003_FFFF}, 32'h1234_5678, 32'h1234_5678, 32'h0,
			32'hFFFF_FFFF);
		send_word({OP_JEQ, 28'hFFF_FFFF}, 32'h1234_5678, 32'h1234_5679, 32'h0,
			32'h0000_1000);
		send_word({OP_AND, 28'hA5A_5A5A}, 32'h0, 32'hF0F0_F0F0, 32'hFFFF_0000, 32'h0);
		send_word({OP_XORI, 28'h003_FFFF}, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
		send_word({OP_JUMP, 28'hFFF_FFFF}, 32'h0, 32'h0, 32'h0, 32'h0000_0000);
		send_word({OP_JUMP, 28'h000_0000}, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
		send_word({OP_SLL, 28'h000_0000}, 32'h0, 32'h8000_0001, 32'h0, 32'h0);
		send_word({OP_SLL, 28'h000_001F}, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
		send_word({OP_SLL, 28'h000_0020}, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
		send_word({OP_SLL, 28'hFFF_FFFF}, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
		send_word({OP_SRL, 28'h000_0001}, 32'h0, 32'h8000_0000, 32'h0, 32'h0);
		send_word({OP_SRL, 28'h000_0020}, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
		send_word({OP_SRL, 28'h000_1FFF}, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
		send_word({OP_LOAD, 28'hFFF_FFFF}, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
		send_word({OP_STORE, 28'h003_FFFF}, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'h0, 32'h0);
		for (int code = FIRST_ILLEGAL_OP; code < OPCODE_COUNT; code++)
			send_word({code[3:0], 28'hFFF_FFFF}, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
				32'hFFFF_FFFF, 32'hFFFF_FFFF);
		wait_for_drain();
	endtask

	task automatic test_random_mix();
		repeat (1000) send_random_word();
		wait_for_drain();
	endtask

	task automatic test_back_to_back();
		idle_enable = 1'b0;
		repeat (160) send_random_word();
		wait_for_drain();
		idle_enable = 1'b1;
	endtask

	task automatic test_output_hold_off();
		idle_enable = 1'b0;
		hold_off_pending = 1'b1;
		repeat (60) send_random_word();
		wait_for_drain();
		idle_enable = 1'b1;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix();
		test_back_to_back();
		test_output_hold_off();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== instruction_decode_execute.f =====
sv/ide_pkg.sv
sv/ide_front.sv
sv/ide_queue.sv
sv/ide_back.sv
sv/instruction_decode_execute.sv
sv/ide_checker.sv
dv/tb_top.sv
